// ===== hdl/assert_macros.svh =====
// assertion macros used by the rtl top level
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in a cycle implies a check in the same cycle
`define SPST_ASSERT_IMPL(label, cond, check, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (check)) else $error(msg);

// condition in a cycle implies a check in the next cycle
`define SPST_ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (check)) else $error(msg);

`endif

// ===== hdl/spst_pkg.sv =====
// shared constants, codes and types of the sparse page shadow table
// no dependencies
package spst_pkg;

    // geometry
    localparam int unsigned ADDR_BITS   = 48;
    localparam int unsigned PAGE_WORDS  = 512;
    localparam int unsigned NUM_PAGES   = 16;
    localparam int unsigned WORD_BYTES  = 8;
    localparam int unsigned DATA_BITS   = 64;
    localparam int unsigned STAT_BITS   = 2;

    localparam int unsigned BYTE_BITS   = $clog2(WORD_BYTES);
    localparam int unsigned OFFS_BITS   = $clog2(PAGE_WORDS);
    localparam int unsigned PAGE_LSB    = BYTE_BITS + OFFS_BITS;
    localparam int unsigned TAG_BITS    = ADDR_BITS - PAGE_LSB;
    localparam int unsigned SLOT_BITS   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int unsigned CNT_BITS    = $clog2(NUM_PAGES + 1);
    localparam int unsigned IDX_BITS    = SLOT_BITS + OFFS_BITS;
    localparam int unsigned TOTAL_WORDS = NUM_PAGES * PAGE_WORDS;
    localparam int unsigned MEM_BITS    = DATA_BITS + 1;

    // command queue between front and back
    localparam int unsigned QDEPTH      = 2;
    localparam int unsigned QPTR_BITS   = $clog2(QDEPTH);

    // operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_UNALIGNED = 2'd1,
        ST_NO_SLOT   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [IDX_BITS-1:0]    idx;
        logic [DATA_BITS-1:0]   value;
        t_status                status;
    } t_cmd;

    typedef struct packed {
        logic [CNT_BITS-1:0] slots_allocated;
    } t_front_stat;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

// ===== hdl/spst_ifs.sv =====
// valid/ready channels of the sparse page shadow table
// depends on spst_pkg
interface spst_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [spst_pkg::ADDR_BITS-1:0]      address;
    logic [spst_pkg::DATA_BITS-1:0]      write_value;

    modport source (output valid, output op, output address, output write_value,
                    input ready);
    modport sink   (input valid, input op, input address, input write_value,
                    output ready);
endinterface

interface spst_out_if;
    logic                                valid;
    logic                                ready;
    logic [spst_pkg::DATA_BITS-1:0]      read_value;
    logic [spst_pkg::STAT_BITS-1:0]      status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

// ===== hdl/sparse_page_shadow_table_top.sv =====
// top level of the sparse page shadow table: front, command queue, back
// depends on spst_pkg, spst_ifs, spst_front, spst_queue, spst_back
//
//  channel   dir   fields                              handshake
//  i_req     in    op, address[47:0], write_value[63:0] valid/ready
//  o_rsp     out   read_value[63:0], status[1:0]       valid/ready
//
// the front takes at most one item a cycle while the two-entry queue has room
// writes and error or miss results go straight into the result register, lookups that
// hit a page first pass through the registered read of the word memory
// after reset a clearing pass sweeps the 8192 word memory entries, one a
// cycle, and no item is accepted until it ends
// a stalled result holds the back; the front keeps filling the queue
`include "assert_macros.svh"

module sparse_page_shadow_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spst_in_if.sink     i_req,
    spst_out_if.source  o_rsp
);

    spst_pkg::t_cmd         w_push_cmd;
    spst_pkg::t_cmd         w_head_cmd;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_full;
    logic                   w_empty;
    spst_pkg::t_front_stat  w_fstat;
    spst_pkg::t_back_stat   w_bstat;

    // classify and allocate
    spst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_hold  (w_bstat.clearing),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd),
        .o_stat  (w_fstat)
    );

    // decoupling queue
    spst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty)
    );

    // memory access and result
    spst_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_head_cmd),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp),
        .o_stat  (w_bstat)
    );

    // checks
    `SPST_ASSERT_IMPL(a_no_accept_in_clear, w_bstat.clearing, !i_req.ready, "item taken during clearing pass")
    `SPST_ASSERT_NEXT(a_clear_once, !w_bstat.clearing, !w_bstat.clearing, "clearing pass restarted")
    `SPST_ASSERT_IMPL(a_no_slot_when_full, o_rsp.valid && (o_rsp.status == spst_pkg::ST_NO_SLOT), w_fstat.slots_allocated == spst_pkg::CNT_BITS'(spst_pkg::NUM_PAGES), "no-slot result with free slots")
    `SPST_ASSERT_IMPL(a_zero_on_error, o_rsp.valid && (o_rsp.status != spst_pkg::ST_OK), o_rsp.read_value == '0, "nonzero value with error status")

endmodule

// ===== hdl/spst_front.sv =====
// front part: accepts items, checks alignment, owns the page directory
// and turns each item into a command; depends on spst_pkg and spst_ifs
module spst_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    spst_in_if.sink                 i_req,
    input  logic                    i_hold,
    input  logic                    i_full,
    output logic                    o_push,
    output spst_pkg::t_cmd          o_cmd,
    output spst_pkg::t_front_stat   o_stat
);

    logic [spst_pkg::TAG_BITS-1:0]  r_tags [spst_pkg::NUM_PAGES];
    logic [spst_pkg::NUM_PAGES-1:0] r_in_use;
    logic [spst_pkg::CNT_BITS-1:0]  r_slots_alloc;
    logic [spst_pkg::CNT_BITS-1:0]  n_slots_alloc;

    logic                           w_accept;
    logic                           w_aligned;
    logic [spst_pkg::TAG_BITS-1:0]  w_page;
    logic [spst_pkg::OFFS_BITS-1:0] w_offs;
    logic                           w_hit;
    logic [spst_pkg::SLOT_BITS-1:0] w_hit_slot;
    logic [spst_pkg::SLOT_BITS-1:0] w_new_slot;
    logic                           w_dir_full;
    logic                           w_alloc;

    assign i_req.ready = !i_full && !i_hold;
    assign w_accept    = i_req.valid && i_req.ready;
    assign o_push      = w_accept;
    assign o_stat.slots_allocated = r_slots_alloc;

    // address split
    assign w_page    = i_req.address[spst_pkg::ADDR_BITS-1:spst_pkg::PAGE_LSB];
    assign w_offs    = i_req.address[spst_pkg::PAGE_LSB-1:spst_pkg::BYTE_BITS];
    assign w_aligned = (i_req.address[spst_pkg::BYTE_BITS-1:0] == '0);

    // directory search, tags of used slots are unique
    always_comb begin
        w_hit      = 1'b0;
        w_hit_slot = '0;
        for (int s = 0; s < spst_pkg::NUM_PAGES; s++) begin
            if (r_in_use[s] && (r_tags[s] == w_page)) begin
                w_hit      = 1'b1;
                w_hit_slot = w_hit_slot | spst_pkg::SLOT_BITS'(s);
            end
        end
    end

    assign w_dir_full = (r_slots_alloc == spst_pkg::CNT_BITS'(spst_pkg::NUM_PAGES));
    assign w_new_slot = r_slots_alloc[spst_pkg::SLOT_BITS-1:0];

    // classify the item
    always_comb begin
        o_cmd.kind   = spst_pkg::CMD_NONE;
        o_cmd.idx    = {w_hit_slot, w_offs};
        o_cmd.value  = i_req.write_value;
        o_cmd.status = spst_pkg::ST_OK;
        w_alloc      = 1'b0;
        priority if (!w_aligned) begin
            o_cmd.status = spst_pkg::ST_UNALIGNED;
        end else if (i_req.op == spst_pkg::OP_LOOKUP) begin
            if (w_hit) begin
                o_cmd.kind = spst_pkg::CMD_READ;
            end
        end else if (w_hit) begin
            o_cmd.kind = spst_pkg::CMD_WRITE;
        end else if (!w_dir_full) begin
            o_cmd.kind = spst_pkg::CMD_WRITE;
            o_cmd.idx  = {w_new_slot, w_offs};
            w_alloc    = 1'b1;
        end else begin
            o_cmd.status = spst_pkg::ST_NO_SLOT;
        end
    end

    assign n_slots_alloc = r_slots_alloc + spst_pkg::CNT_BITS'(1);

    // slot allocation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use      <= '0;
            r_slots_alloc <= '0;
        end else if (w_accept && w_alloc) begin
            r_in_use[w_new_slot] <= 1'b1;
            r_slots_alloc        <= n_slots_alloc;
        end
    end

    // page tags, meaningful only where the slot is in use
    always_ff @(posedge i_clk) begin
        if (w_accept && w_alloc) begin
            r_tags[w_new_slot] <= w_page;
        end
    end

endmodule

// ===== hdl/spst_queue.sv =====
// short command queue between front and back
// depends on spst_pkg
module spst_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  spst_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output spst_pkg::t_cmd  o_cmd,
    output logic            o_empty
);

    spst_pkg::t_cmd                r_entries [spst_pkg::QDEPTH];
    logic [spst_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [spst_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [spst_pkg::QPTR_BITS:0]   r_count;
    logic                           w_push;
    logic                           w_pop;

    assign o_full  = (r_count == (spst_pkg::QPTR_BITS+1)'(spst_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_entries[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + spst_pkg::QPTR_BITS'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + spst_pkg::QPTR_BITS'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (spst_pkg::QPTR_BITS+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (spst_pkg::QPTR_BITS+1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hdl/spst_back.sv =====
// back part: word memory with written flags, clearing pass after reset,
// result register; depends on spst_pkg and spst_ifs
module spst_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  spst_pkg::t_cmd          i_cmd,
    input  logic                    i_empty,
    output logic                    o_pop,
    spst_out_if.source              o_rsp,
    output spst_pkg::t_back_stat    o_stat
);

    // word memory, top bit marks a written word
    logic [spst_pkg::MEM_BITS-1:0]  r_mem [spst_pkg::TOTAL_WORDS];
    logic [spst_pkg::MEM_BITS-1:0]  r_rd_word;

    logic                           r_clearing;
    logic                           n_clearing;
    logic [spst_pkg::IDX_BITS-1:0]  r_clr_idx;
    logic [spst_pkg::IDX_BITS-1:0]  n_clr_idx;
    logic                           r_busy;
    logic                           n_busy;

    logic                           r_out_valid;
    logic [spst_pkg::DATA_BITS-1:0] r_out_value;
    spst_pkg::t_status              r_out_status;

    logic                           w_can_load;
    logic                           w_mem_we;
    logic                           w_mem_re;
    logic [spst_pkg::IDX_BITS-1:0]  w_waddr;
    logic [spst_pkg::MEM_BITS-1:0]  w_wdata;
    logic                           w_load;
    logic [spst_pkg::DATA_BITS-1:0] w_load_value;
    spst_pkg::t_status              w_load_status;

    assign w_can_load      = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.status    = r_out_status;
    assign o_stat.clearing = r_clearing;

    // command execution
    always_comb begin
        o_pop         = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_re      = 1'b0;
        w_waddr       = r_clr_idx;
        w_wdata       = '0;
        w_load        = 1'b0;
        w_load_value  = '0;
        w_load_status = spst_pkg::ST_OK;
        n_busy        = r_busy;
        n_clearing    = r_clearing;
        n_clr_idx     = r_clr_idx;
        priority if (r_clearing) begin
            w_mem_we  = 1'b1;
            n_clr_idx = r_clr_idx + spst_pkg::IDX_BITS'(1);
            if (r_clr_idx == spst_pkg::IDX_BITS'(spst_pkg::TOTAL_WORDS - 1)) begin
                n_clearing = 1'b0;
            end
        end else if (r_busy) begin
            if (w_can_load) begin
                w_load       = 1'b1;
                w_load_value = r_rd_word[spst_pkg::MEM_BITS-1] ?
                               r_rd_word[spst_pkg::DATA_BITS-1:0] : '0;
                n_busy       = 1'b0;
            end
        end else if (!i_empty) begin
            unique case (i_cmd.kind)
                spst_pkg::CMD_READ: begin
                    o_pop    = 1'b1;
                    w_mem_re = 1'b1;
                    n_busy   = 1'b1;
                end
                spst_pkg::CMD_WRITE: begin
                    if (w_can_load) begin
                        o_pop    = 1'b1;
                        w_mem_we = 1'b1;
                        w_waddr  = i_cmd.idx;
                        w_wdata  = {1'b1, i_cmd.value};
                        w_load   = 1'b1;
                    end
                end
                default: begin
                    if (w_can_load) begin
                        o_pop         = 1'b1;
                        w_load        = 1'b1;
                        w_load_status = i_cmd.status;
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_idx  <= n_clr_idx;
            r_busy     <= n_busy;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value  <= w_load_value;
            r_out_status <= w_load_status;
        end
    end

    // word memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_mem_re) begin
            r_rd_word <= r_mem[i_cmd.idx];
        end
    end

endmodule

// ===== tb/tb_sparse_page_shadow_table_top.sv =====
// testbench of sparse_page_shadow_table_top: directed table, then random writes and lookups
// checked in order against a behavioral shadow of the page directory and word store
// depends on spst_pkg, spst_ifs and the rtl of the block
module tb_sparse_page_shadow_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spst_pkg::*;

    localparam int unsigned RANDOM_ITEMS     = 1380;
    localparam int unsigned QUIET_FROM       = 300;
    localparam int unsigned QUIET_TO         = 450;
    localparam int unsigned LONG_HOLD_AT     = 500;
    localparam int unsigned LONG_HOLD_CYCLES = 64;
    localparam int unsigned DRAIN_PAUSE_AT   = 900;
    localparam int unsigned DRAIN_CYCLES     = 16;
    localparam int unsigned IDLE_LIMIT       = 40000;
    localparam int unsigned HIST_DEPTH       = 64;
    localparam int unsigned MAX_REPORTS      = 10;

    typedef struct {
        logic                 op;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] wval;
        bit                   typed;
        logic [DATA_BITS-1:0] rd;
        t_status              st;
    } t_stim_row;

    typedef struct {
        logic [DATA_BITS-1:0] rd;
        t_status              st;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    spst_in_if  req_if ();
    spst_out_if rsp_if ();

    sparse_page_shadow_table_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the directory and the word store
    logic [TAG_BITS-1:0]  dir_tag [NUM_PAGES];
    bit                   dir_used [NUM_PAGES];
    int unsigned          dir_count = 0;
    logic [DATA_BITS-1:0] shadow_words [int unsigned];

    t_stim_row            stim_rows [$];
    t_rsp                 pending_rsp_q [$];
    logic [ADDR_BITS-1:0] written_addr_hist [$];

    int unsigned          mismatch_count = 0;
    int unsigned          results_seen = 0;
    int unsigned          idle_cycles = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // expected result of one item, updates the shadow state
    function automatic t_rsp shadow_step(input logic op, input logic [ADDR_BITS-1:0] addr,
                                         input logic [DATA_BITS-1:0] wval);
        t_rsp                r;
        logic [TAG_BITS-1:0] page;
        int unsigned         offs;
        int                  slot;
        int                  s;
        int unsigned         w;
        r.rd = '0;
        r.st = ST_OK;
        if (addr[BYTE_BITS-1:0] != '0) begin
            r.st = ST_UNALIGNED;
            return r;
        end
        page = addr[ADDR_BITS-1:PAGE_LSB];
        offs = addr[PAGE_LSB-1:BYTE_BITS];
        slot = -1;
        for (s = 0; s < NUM_PAGES; s++) begin
            if (slot < 0 && dir_used[s] && dir_tag[s] == page) slot = s;
        end
        if (op == OP_WRITE) begin
            if (slot < 0) begin
                // new page: take the next slot or report a full directory
                if (dir_count >= NUM_PAGES) begin
                    r.st = ST_NO_SLOT;
                    return r;
                end
                slot = int'(dir_count);
                dir_count++;
                dir_used[slot] = 1'b1;
                dir_tag[slot]  = page;
                for (w = 0; w < PAGE_WORDS; w++) begin
                    shadow_words.delete(slot * PAGE_WORDS + w);
                end
            end
            shadow_words[slot * PAGE_WORDS + offs] = wval;
        end else if (slot >= 0) begin
            if (shadow_words.exists(slot * PAGE_WORDS + offs))
                r.rd = shadow_words[slot * PAGE_WORDS + offs];
        end
        return r;
    endfunction

    // address for a random item: mostly known pages and recently written words
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [ADDR_BITS-1:0] a;
        logic [63:0]          raw;
        int unsigned          r;
        int unsigned          idx;
        raw = {$urandom, $urandom};
        a   = raw[ADDR_BITS-1:0];
        r   = $urandom_range(0, 99);
        if (r < 5) begin
            // unaligned, sometimes on a written word
            if (written_addr_hist.size() != 0 && $urandom_range(0, 1) == 0)
                a = written_addr_hist[$urandom_range(0, written_addr_hist.size() - 1)];
            a[BYTE_BITS-1:0] = raw[BYTE_BITS+47:48];
            if (a[BYTE_BITS-1:0] == '0) a[0] = 1'b1;
        end else if (r < 45 && written_addr_hist.size() != 0) begin
            // newest written word half of the time
            if ($urandom_range(0, 1) == 0)
                idx = written_addr_hist.size() - 1;
            else
                idx = $urandom_range(0, written_addr_hist.size() - 1);
            a = written_addr_hist[idx];
        end else if (r < 94 && dir_count != 0) begin
            a[ADDR_BITS-1:PAGE_LSB] = dir_tag[$urandom_range(0, dir_count - 1)];
            case ($urandom_range(0, 9))
                0:       a[PAGE_LSB-1:BYTE_BITS] = '0;
                1:       a[PAGE_LSB-1:BYTE_BITS] = '1;
                default: a[PAGE_LSB-1:BYTE_BITS] = raw[OFFS_BITS-1:0];
            endcase
            a[BYTE_BITS-1:0] = '0;
        end else begin
            // most likely a page never seen
            a[BYTE_BITS-1:0] = '0;
        end
        return a;
    endfunction

    task automatic add_row(input logic op, input logic [ADDR_BITS-1:0] addr,
                           input logic [DATA_BITS-1:0] wval, input bit typed,
                           input logic [DATA_BITS-1:0] rd, input t_status st);
        t_stim_row row;
        row.op    = op;
        row.addr  = addr;
        row.wval  = wval;
        row.typed = typed;
        row.rd    = rd;
        row.st    = st;
        stim_rows.push_back(row);
    endtask

    // offer one item after a random gap, record its expected result on acceptance
    task automatic send_item(input t_stim_row row, input bit no_gap);
        int unsigned gap;
        t_rsp        want;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid       <= 1'b1;
        req_if.op          <= row.op;
        req_if.address     <= row.addr;
        req_if.write_value <= row.wval;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        want = shadow_step(row.op, row.addr, row.wval);
        if (row.typed) begin
            want.rd = row.rd;
            want.st = row.st;
        end
        pending_rsp_q.push_back(want);
    endtask

    // sender: reset, directed table, random items, end of run
    initial begin
        t_stim_row   row;
        logic [63:0] raw;
        int unsigned n;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.op          <= OP_WRITE;
        req_if.address     <= '0;
        req_if.write_value <= '0;

        // directed rows: empty directory, unaligned cases, extremes of page and offset
        add_row(OP_LOOKUP, 48'h0000_0000_0000, 64'h0, 1'b1, 64'h0, ST_OK);
        add_row(OP_LOOKUP, 48'hFFFF_FFFF_FFF8, '1, 1'b1, 64'h0, ST_OK);
        add_row(OP_WRITE,  48'h0000_0000_0001, '1, 1'b1, 64'h0, ST_UNALIGNED);
        add_row(OP_WRITE,  48'hFFFF_FFFF_FFFF, '1, 1'b1, 64'h0, ST_UNALIGNED);
        add_row(OP_LOOKUP, 48'h0000_0000_0004, 64'h0, 1'b1, 64'h0, ST_UNALIGNED);
        add_row(OP_WRITE,  48'h0000_0000_0000, '1, 1'b1, 64'h0, ST_OK);
        add_row(OP_LOOKUP, 48'h0000_0000_0000, 64'h0, 1'b1, '1, ST_OK);
        // unwritten word of a known page
        add_row(OP_LOOKUP, 48'h0000_0000_0008, 64'h0, 1'b1, 64'h0, ST_OK);
        add_row(OP_LOOKUP, 48'h0000_0000_0007, 64'h0, 1'b1, 64'h0, ST_UNALIGNED);
        add_row(OP_WRITE,  48'hFFFF_FFFF_FFF8, 64'h8000_0000_0000_0001, 1'b1, 64'h0, ST_OK);
        add_row(OP_LOOKUP, 48'hFFFF_FFFF_FFF8, 64'h0, 1'b0, 64'h0, ST_OK);
        add_row(OP_WRITE,  48'h0000_0000_0FF8, 64'h0123_4567_89AB_CDEF, 1'b1, 64'h0, ST_OK);
        add_row(OP_LOOKUP, 48'h0000_0000_0FF8, 64'h0, 1'b0, 64'h0, ST_OK);
        add_row(OP_LOOKUP, 48'h0000_0000_1000, '1, 1'b1, 64'h0, ST_OK);
        add_row(OP_WRITE,  48'h0000_0000_1000, 64'h5555_5555_5555_5555, 1'b1, 64'h0, ST_OK);
        add_row(OP_LOOKUP, 48'h0000_0000_1000, 64'h0, 1'b0, 64'h0, ST_OK);
        add_row(OP_WRITE,  48'h0000_0000_0000, 64'h0, 1'b1, 64'h0, ST_OK);
        add_row(OP_LOOKUP, 48'h0000_0000_0000, '1, 1'b0, 64'h0, ST_OK);
        add_row(OP_WRITE,  48'hFFFF_FFFF_F000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'h0, ST_OK);
        add_row(OP_LOOKUP, 48'hFFFF_FFFF_F000, 64'h0, 1'b0, 64'h0, ST_OK);
        add_row(OP_LOOKUP, 48'hFFFF_FFFF_FFF8, 64'h0, 1'b0, 64'h0, ST_OK);
        // a rejected unaligned write must not allocate its page
        add_row(OP_WRITE,  48'h8000_0000_0007, '1, 1'b1, 64'h0, ST_UNALIGNED);
        add_row(OP_LOOKUP, 48'h8000_0000_0000, 64'h0, 1'b1, 64'h0, ST_OK);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) send_item(stim_rows[k], 1'b0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // let the block run dry once
            if (n == DRAIN_PAUSE_AT) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                while (pending_rsp_q.size() != 0) @(posedge i_clk);
            end
            raw       = {$urandom, $urandom};
            row.op    = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_LOOKUP;
            row.addr  = pick_address();
            row.typed = 1'b0;
            row.rd    = '0;
            row.st    = ST_OK;
            case ($urandom_range(0, 9))
                0:       row.wval = '0;
                1:       row.wval = '1;
                default: row.wval = raw;
            endcase
            if (row.op == OP_WRITE && row.addr[BYTE_BITS-1:0] == '0) begin
                written_addr_hist.push_back(row.addr);
                if (written_addr_hist.size() > HIST_DEPTH) void'(written_addr_hist.pop_front());
            end
            send_item(row, n >= QUIET_FROM && n < QUIET_TO);
        end

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // receiver: random hold-off per item, one long hold, in-order compare
    initial begin
        int unsigned hold;
        t_rsp        want;
        rsp_if.ready <= 1'b0;
        // skip the clock's first falling edge at time zero
        @(posedge i_clk);
        forever begin
            if (results_seen == LONG_HOLD_AT)
                hold = LONG_HOLD_CYCLES;
            else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO)
                hold = 0;
            else
                hold = $urandom_range(0, 7);
            repeat (hold) begin
                @(negedge i_clk);
                rsp_if.ready <= 1'b0;
                @(posedge i_clk);
            end
            @(negedge i_clk);
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_if.valid !== 1'b1);
            if (pending_rsp_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result %0d: read_value %h status %0d",
                             results_seen, rsp_if.read_value, rsp_if.status);
            end else begin
                want = pending_rsp_q.pop_front();
                if (rsp_if.read_value !== want.rd || rsp_if.status !== want.st) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result %0d: expected read_value %h status %0d, got %h %0d",
                                 results_seen, want.rd, want.st,
                                 rsp_if.read_value, rsp_if.status);
                end
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no item moving on either channel
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/spst_pkg.sv
hdl/spst_ifs.sv
hdl/spst_front.sv
hdl/spst_queue.sv
hdl/spst_back.sv
hdl/sparse_page_shadow_table_top.sv
tb/tb_sparse_page_shadow_table_top.sv
